>>> hw/rtl/mste_pkg.sv
// Shared types, constants and helper functions for the MPE section to Ethernet converter.
package mste_pkg;

	// Section byte counter, saturating at its all-ones value.
	localparam int unsigned CountW = 13;
	localparam logic [CountW-1:0] CountMax = '1;

	// Default maximum payload length in bytes.
	localparam int unsigned MaxPayloadDef = 1500;

	// Command queue between the classifier and the result sequencer.
	localparam int unsigned QueueDepth = 16;
	localparam int unsigned QueueAw = $clog2(QueueDepth);

	// Byte positions within a section.
	localparam logic [CountW-1:0] PosMac5     = 13'd3;
	localparam logic [CountW-1:0] PosMac4     = 13'd4;
	localparam logic [CountW-1:0] PosCtrl     = 13'd5;
	localparam logic [CountW-1:0] PosMac3     = 13'd8;
	localparam logic [CountW-1:0] PosMac2     = 13'd9;
	localparam logic [CountW-1:0] PosMac1     = 13'd10;
	localparam logic [CountW-1:0] PosMac0     = 13'd11;
	localparam logic [CountW-1:0] PosIpHdr    = 13'd12;
	localparam logic [CountW-1:0] PosSnapLast = 13'd17;
	localparam logic [CountW-1:0] PosTypeHi   = 13'd18;
	localparam logic [CountW-1:0] PosTypeLo   = 13'd19;
	localparam logic [CountW-1:0] PosPayPlain = 13'd16;
	localparam logic [CountW-1:0] PosPaySnap  = 13'd24;

	// Control byte flags and EtherType values.
	localparam logic [7:0]  ScrambleMask = 8'h3c;
	localparam logic [7:0]  SnapFlag     = 8'h02;
	localparam logic [3:0]  Ipv6Version  = 4'h6;
	localparam logic [15:0] EtherIpv6    = 16'h86dd;
	localparam logic [15:0] EtherIpv4    = 16'h0800;

	// The Ethernet header is fourteen bytes long.
	localparam logic [3:0] HdrBytes = 4'd14;
	localparam logic [3:0] HdrMacEnd = 4'd6;
	localparam logic [3:0] HdrTypeHi = 4'd12;
	localparam logic [3:0] HdrTypeLo = 4'd13;

	// End-of-section status codes.
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SHORT     = 3'd1,
		ST_SCRAMBLED = 3'd2,
		ST_BAD_SNAP  = 3'd3,
		ST_OVERSIZED = 3'd4
	} status_t;

	// One queued command: a header burst, a payload byte, a status, or a byte then a status.
	typedef struct packed {
		logic            hdr;
		logic            has_data;
		logic [7:0]      data;
		logic            has_status;
		status_t         status;
		logic [5:0][7:0] mac;
		logic [15:0]     ether_type;
	} cmd_t;

	// Expected LLC/SNAP header byte at offset k from byte 12.
	function automatic logic [7:0] snap_byte(input logic [2:0] k);
		logic [7:0] v;
		case (k)
			3'd0, 3'd1: v = 8'haa;
			3'd2:       v = 8'h03;
			default:    v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

>>> hw/rtl/mpe_section_to_ethernet.sv
// Top level of the MPE section to Ethernet frame converter.
//
//  Channel  Direction  Handshake            Payload
//  in       sink       in_valid / in_stall   in_byte, section_last
//  out      source     out_valid / out_stall out_byte, is_data, frame_end, status
//
// One section byte is taken per cycle while the queue has room; each frame byte or status
// leaves at one per cycle unless stalled. The fourteen-byte header burst occupies the
// result sequencer, and the 16-entry queue absorbs the input bytes that arrive meanwhile.
// Input stalls only while that queue is full. Results pass through one output register.
// Reset clears the section state, the queue pointers and the output valid flag.
module mpe_section_to_ethernet #(
	parameter int unsigned MAX_PAYLOAD = mste_pkg::MaxPayloadDef
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       section_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       is_data,
	output logic       frame_end,
	output logic [2:0] status
);
	import mste_pkg::*;

	cmd_t    cmd_in;
	cmd_t    cmd_head;
	logic    cmd_push;
	logic    cmd_full;
	logic    cmd_pop;
	logic    cmd_empty;
	status_t status_w;

	// Byte classifier.
	mste_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.section_last (section_last),
		.cmd          (cmd_in),
		.cmd_push     (cmd_push),
		.cmd_full     (cmd_full)
	);

	// Command queue.
	mste_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.dout   (cmd_head),
		.empty  (cmd_empty)
	);

	// Result sequencer.
	mste_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (cmd_head),
		.head_vld  (!cmd_empty),
		.pop       (cmd_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.is_data   (is_data),
		.frame_end (frame_end),
		.status    (status_w)
	);

	assign status = status_w;

endmodule

>>> hw/rtl/mste_front.sv
// Section byte classifier: tracks the section header and issues commands to the queue.
module mste_front #(
	parameter int unsigned MAX_PAYLOAD = mste_pkg::MaxPayloadDef
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [7:0]     in_byte,
	input  logic           section_last,
	output mste_pkg::cmd_t cmd,
	output logic           cmd_push,
	input  logic           cmd_full
);
	import mste_pkg::*;

	// Payload limits, counted from the section start.
	localparam logic [CountW:0] OverLimPlain = (CountW+1)'(MAX_PAYLOAD + 16);
	localparam logic [CountW:0] OverLimSnap  = (CountW+1)'(MAX_PAYLOAD + 24);

	logic [CountW-1:0] count_q;
	logic [5:0][7:0]   mac_q;
	logic [15:0]       ether_q;
	logic              snap_q;
	status_t           drop_q;
	logic [3:0][7:0]   delay_q;
	logic              hdr_sent_q;

	logic [CountW-1:0] j;
	logic [CountW-1:0] rel;
	logic [CountW-1:0] cnt_n;
	logic [5:0][7:0]   mac_n;
	logic [15:0]       ether_n;
	logic              snap_n;
	status_t           drop_n;
	status_t           st_n;
	logic              hdr_go;
	logic              in_win;
	logic              over;
	logic              data_go;
	logic              accept;

	assign accept   = in_valid && !cmd_full;
	assign in_stall = cmd_full;

	// Classify the current byte from its position in the section.
	always_comb begin
		j       = count_q;
		rel     = j - PosIpHdr;
		mac_n   = mac_q;
		ether_n = ether_q;
		snap_n  = snap_q;
		drop_n  = drop_q;
		case (j)
			PosMac5: mac_n[5] = in_byte;
			PosMac4: mac_n[4] = in_byte;
			PosMac3: mac_n[3] = in_byte;
			PosMac2: mac_n[2] = in_byte;
			PosMac1: mac_n[1] = in_byte;
			PosMac0: mac_n[0] = in_byte;
			PosCtrl: begin
				if ((in_byte & ScrambleMask) != 8'h00) begin
					if (drop_n == ST_OK) drop_n = ST_SCRAMBLED;
				end else if ((in_byte & SnapFlag) != 8'h00) begin
					snap_n = 1'b1;
				end
			end
			default: ;
		endcase

		if (snap_n) begin
			if (j >= PosIpHdr && j <= PosSnapLast && in_byte != snap_byte(rel[2:0])
				&& drop_n == ST_OK) begin
				drop_n = ST_BAD_SNAP;
			end
			if (j == PosTypeHi) ether_n[15:8] = in_byte;
			if (j == PosTypeLo) ether_n[7:0] = in_byte;
		end else if (j == PosIpHdr) begin
			ether_n = (in_byte[7:4] == Ipv6Version) ? EtherIpv6 : EtherIpv4;
		end

		// The header goes out once the EtherType is known.
		hdr_go = !hdr_sent_q && drop_n == ST_OK && !section_last
			&& j == (snap_n ? PosTypeLo : PosIpHdr);

		// Payload window and size check.
		in_win = snap_n ? (j >= PosPaySnap) : (j >= PosPayPlain);
		over   = snap_n ? ({1'b0, j} >= OverLimSnap) : ({1'b0, j} >= OverLimPlain);
		if (in_win && drop_n == ST_OK && over) drop_n = ST_OVERSIZED;
		data_go = in_win && drop_n == ST_OK && hdr_sent_q;

		cnt_n = (j == CountMax) ? j : j + 1'b1;

		// Final status, in priority order.
		if (cnt_n < PosPayPlain) st_n = ST_SHORT;
		else if (drop_n != ST_OK) st_n = drop_n;
		else if (snap_n && cnt_n < PosPaySnap) st_n = ST_BAD_SNAP;
		else st_n = ST_OK;
	end

	// Command to the queue.
	always_comb begin
		cmd.hdr        = hdr_go;
		cmd.has_data   = data_go;
		cmd.data       = delay_q[0];
		cmd.has_status = section_last;
		cmd.status     = st_n;
		cmd.mac        = mac_q;
		cmd.ether_type = ether_n;
		cmd_push       = accept && (hdr_go || data_go || section_last);
	end

	// Section state; everything clears after the final byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			mac_q      <= '0;
			ether_q    <= '0;
			snap_q     <= 1'b0;
			drop_q     <= ST_OK;
			delay_q    <= '0;
			hdr_sent_q <= 1'b0;
		end else if (accept) begin
			if (section_last) begin
				count_q    <= '0;
				mac_q      <= '0;
				ether_q    <= '0;
				snap_q     <= 1'b0;
				drop_q     <= ST_OK;
				delay_q    <= '0;
				hdr_sent_q <= 1'b0;
			end else begin
				count_q    <= cnt_n;
				mac_q      <= mac_n;
				ether_q    <= ether_n;
				snap_q     <= snap_n;
				drop_q     <= drop_n;
				delay_q    <= {in_byte, delay_q[3:1]};
				hdr_sent_q <= hdr_sent_q || hdr_go;
			end
		end
	end

endmodule

>>> hw/rtl/mste_queue.sv
// Command queue that decouples byte classification from result sequencing.
module mste_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mste_pkg::cmd_t din,
	output logic           full,
	input  logic           pop,
	output mste_pkg::cmd_t dout,
	output logic           empty
);
	import mste_pkg::*;

	cmd_t               mem_q [QueueDepth];
	logic [QueueAw-1:0] wr_ptr_q;
	logic [QueueAw-1:0] rd_ptr_q;
	logic [QueueAw:0]   level_q;
	logic               do_push;
	logic               do_pop;

	assign full    = (level_q == (QueueAw+1)'(QueueDepth));
	assign empty   = (level_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= din;
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) level_q <= level_q + 1'b1;
			else if (do_pop && !do_push) level_q <= level_q - 1'b1;
		end
	end

endmodule

>>> hw/rtl/mste_back.sv
// Result sequencer: expands queued commands into frame bytes and status results.
module mste_back (
	input  logic              clk,
	input  logic              arst_n,
	input  mste_pkg::cmd_t    head,
	input  logic              head_vld,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        out_byte,
	output logic              is_data,
	output logic              frame_end,
	output mste_pkg::status_t status
);
	import mste_pkg::*;

	logic [3:0] idx_q;
	logic [3:0] n_res;
	logic       load;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       data_q;
	logic       end_q;
	status_t    status_q;
	logic [7:0] byte_n;
	logic       data_n;
	logic       end_n;
	status_t    status_n;

	assign load = head_vld && (!out_valid_q || !out_stall);
	assign pop  = load && (idx_q == n_res - 1'b1);

	// Result count and selection for the command at the queue head.
	always_comb begin
		if (head.hdr) n_res = HdrBytes;
		else n_res = {3'b000, head.has_data} + {3'b000, head.has_status};

		byte_n   = 8'h00;
		data_n   = 1'b1;
		end_n    = 1'b0;
		status_n = ST_OK;
		if (head.hdr) begin
			if (idx_q < HdrMacEnd) byte_n = head.mac[idx_q[2:0]];
			else if (idx_q == HdrTypeHi) byte_n = head.ether_type[15:8];
			else if (idx_q == HdrTypeLo) byte_n = head.ether_type[7:0];
		end else if (head.has_data && idx_q == 4'd0) begin
			byte_n = head.data;
		end else begin
			data_n   = 1'b0;
			end_n    = 1'b1;
			status_n = head.status;
		end
	end

	// Position within the current command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (load) begin
			idx_q <= pop ? 4'd0 : idx_q + 1'b1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q   <= byte_n;
			data_q   <= data_n;
			end_q    <= end_n;
			status_q <= status_n;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = byte_q;
	assign is_data   = data_q;
	assign frame_end = end_q;
	assign status    = status_q;

endmodule

>>> hw/rtl/mste_checker.sv
// Port-level checker for the MPE section to Ethernet converter, with its bind.
module mste_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] in_byte,
	input logic       section_last,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       is_data,
	input logic       frame_end,
	input logic [2:0] status
);

	// A stalled section byte holds until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_byte) && $stable(section_last))
		else $error("section byte changed while stalled");

	// A stalled result holds until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(is_data)
			&& $stable(frame_end) && $stable(status))
		else $error("result changed while stalled");

	// Every result is either a frame byte or the closing status, never both.
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_end == !is_data))
		else $error("result is neither frame byte nor status");

	// Frame bytes carry an ok status.
	a_data_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_data |-> status == 3'd0)
		else $error("frame byte with nonzero status");

	// A status result carries a zero byte and a defined code.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_data |-> out_byte == 8'h00 && status <= 3'd4)
		else $error("malformed status result");

endmodule

bind mpe_section_to_ethernet mste_checker u_chk (.*);

>>> tb/sv/tb_top.sv
// Self-checking testbench for the MPE section to Ethernet frame converter.
`timescale 1ns / 100ps

import mste_pkg::*;

// One expected result of the converter: a frame byte or the section status.
typedef struct {
	logic [7:0] data;
	logic       is_data;
	logic       frame_end;
	status_t    st;
} frame_result_t;

// Kinds of section that the random stimulus builds.
typedef enum {
	SEC_PLAIN,
	SEC_SNAP,
	SEC_BAD_SNAP,
	SEC_SCRAMBLED,
	SEC_SHORT,
	SEC_HDR_ON_LAST,
	SEC_SNAP_SHORT,
	SEC_OVERSIZED,
	SEC_NOISE
} section_kind_t;

// Tracks the section being decapsulated and holds the frame bytes and statuses still due.
class section_scoreboard;
	frame_result_t expected_q[$];
	int unsigned   max_payload;
	int            errors;

	logic [CountW-1:0] byte_count;
	logic [7:0]        dest_mac[6];
	logic [15:0]       ether_type;
	logic              snap_mode;
	status_t           drop_code;
	logic [7:0]        crc_delay[4];
	logic              header_sent;

	function new(int unsigned max_payload);
		this.max_payload = max_payload;
		errors = 0;
		clear_section();
	endfunction

	function void clear_section();
		byte_count = '0;
		foreach (dest_mac[i]) dest_mac[i] = 8'h00;
		ether_type = 16'h0000;
		snap_mode = 1'b0;
		drop_code = ST_OK;
		foreach (crc_delay[i]) crc_delay[i] = 8'h00;
		header_sent = 1'b0;
	endfunction

	function void push_result(logic [7:0] data, logic is_data, logic frame_end, status_t st);
		frame_result_t r;
		r.data = data;
		r.is_data = is_data;
		r.frame_end = frame_end;
		r.st = st;
		expected_q.push_back(r);
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	// Works out the results caused by one accepted section byte.
	function void note_section_byte(logic [7:0] b, logic last);
		int unsigned j;
		int unsigned snap_off;
		int unsigned cnt;
		logic [7:0]  want;
		logic [7:0]  leaving;
		status_t     end_status;

		j = byte_count;
		snap_off = snap_mode ? 8 : 0;

		// Header fields: MAC bytes and the control byte.
		case (j)
			3: dest_mac[5] = b;
			4: dest_mac[4] = b;
			8: dest_mac[3] = b;
			9: dest_mac[2] = b;
			10: dest_mac[1] = b;
			11: dest_mac[0] = b;
			5: begin
				if ((b & ScrambleMask) != 8'h00) begin
					if (drop_code == ST_OK) drop_code = ST_SCRAMBLED;
				end else if ((b & SnapFlag) != 8'h00) begin
					snap_mode = 1'b1;
					snap_off = 8;
				end
			end
			default: ;
		endcase

		// LLC/SNAP header check and EtherType capture.
		if (snap_mode) begin
			want = (j <= 13) ? 8'haa : (j == 14) ? 8'h03 : 8'h00;
			if (j >= 12 && j <= 17 && b != want && drop_code == ST_OK)
				drop_code = ST_BAD_SNAP;
			if (j == 18) ether_type[15:8] = b;
			if (j == 19) ether_type[7:0] = b;
		end else if (j == 12) begin
			ether_type = (b[7:4] == Ipv6Version) ? EtherIpv6 : EtherIpv4;
		end

		// The fourteen-byte Ethernet header, once the EtherType is known.
		if (!header_sent && drop_code == ST_OK && !last && j == (snap_mode ? 19 : 12)) begin
			for (int i = 0; i < 6; i++) push_result(dest_mac[i], 1'b1, 1'b0, ST_OK);
			for (int i = 0; i < 6; i++) push_result(8'h00, 1'b1, 1'b0, ST_OK);
			push_result(ether_type[15:8], 1'b1, 1'b0, ST_OK);
			push_result(ether_type[7:0], 1'b1, 1'b0, ST_OK);
			header_sent = 1'b1;
		end

		// Payload leaves four bytes late so that the CRC is held back.
		leaving = crc_delay[0];
		crc_delay[0] = crc_delay[1];
		crc_delay[1] = crc_delay[2];
		crc_delay[2] = crc_delay[3];
		crc_delay[3] = b;
		if (j >= 16 + snap_off) begin
			if (drop_code == ST_OK && j - 16 - snap_off >= max_payload)
				drop_code = ST_OVERSIZED;
			if (drop_code == ST_OK && header_sent)
				push_result(leaving, 1'b1, 1'b0, ST_OK);
		end

		cnt = (j < CountMax) ? j + 1 : CountMax;
		byte_count = cnt[CountW-1:0];

		// Status closes the section.
		if (last) begin
			if (cnt < 16) end_status = ST_SHORT;
			else if (drop_code != ST_OK) end_status = drop_code;
			else if (snap_mode && cnt < 24) end_status = ST_BAD_SNAP;
			else end_status = ST_OK;
			push_result(8'h00, 1'b0, 1'b1, end_status);
			clear_section();
		end
	endfunction

	task report_mismatch(string msg);
		errors++;
		if (errors <= 40) $display("mismatch: %s", msg);
	endtask

	// Compares one result transfer with the oldest expectation.
	task check_result(logic [7:0] data, logic is_data, logic frame_end, logic [2:0] st);
		frame_result_t want;
		if (expected_q.size() == 0) begin
			report_mismatch($sformatf("unexpected result byte %02h is_data %0b status %0d",
				data, is_data, st));
			return;
		end
		want = expected_q.pop_front();
		if (data !== want.data)
			report_mismatch($sformatf("out_byte %02h, want %02h", data, want.data));
		if (is_data !== want.is_data)
			report_mismatch($sformatf("is_data %0b, want %0b", is_data, want.is_data));
		if (frame_end !== want.frame_end)
			report_mismatch($sformatf("frame_end %0b, want %0b", frame_end, want.frame_end));
		if (st !== want.st)
			report_mismatch($sformatf("status %0d, want %0d", st, want.st));
	endtask
endclass

module tb_top;

	localparam int ClkPeriod = 4;
	localparam int MaxPayload = 64;
	localparam int WatchdogLimit = 2000;
	localparam int DrainCycles = 40;
	localparam int RandomBytes = 270;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte = 8'h00;
	logic       section_last = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       is_data;
	logic       frame_end;
	logic [2:0] status;

	logic steady = 1'b0;
	int   sent_bytes = 0;
	int   idle_cycles = 0;

	section_scoreboard sb = new(MaxPayload);

	always #(ClkPeriod / 2) clk = ~clk;

	mpe_section_to_ethernet #(
		.MAX_PAYLOAD(MaxPayload)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.section_last(section_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.is_data(is_data),
		.frame_end(frame_end),
		.status(status)
	);

	// The receiver stalls now and then, except during the steady stretch.
	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(0, 99) < 8);
	end

	// Result transfers are checked and progress is watched mid-cycle, where everything is stable.
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_byte, is_data, frame_end, status);
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("timeout: no transfer for %0d cycles", WatchdogLimit);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Offers one section byte, with an occasional gap first, and waits for its transfer.
	task drive_byte(logic [7:0] b, logic last);
		while (!steady && $urandom_range(0, 99) < 8) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		section_last <= last;
		@(negedge clk);
		while (in_stall) @(negedge clk);
		sb.note_section_byte(b, last);
		sent_bytes++;
		@(posedge clk);
	endtask

	task drive_section(logic [7:0] sec[$]);
		foreach (sec[i]) drive_byte(sec[i], i == sec.size() - 1);
	endtask

	// Holds the sender back until every expected result has come out.
	task hold_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Builds a section of random content around a randomly chosen shape.
	function automatic void build_section(ref logic [7:0] sec[$]);
		section_kind_t kind;
		int            roll;
		int            len;
		int            pos;
		logic          snap;
		logic [7:0]    ctrl;

		roll = $urandom_range(0, 99);
		if (roll < 40) kind = SEC_PLAIN;
		else if (roll < 60) kind = SEC_SNAP;
		else if (roll < 68) kind = SEC_BAD_SNAP;
		else if (roll < 74) kind = SEC_SCRAMBLED;
		else if (roll < 80) kind = SEC_SHORT;
		else if (roll < 86) kind = SEC_HDR_ON_LAST;
		else if (roll < 90) kind = SEC_SNAP_SHORT;
		else if (roll < 96) kind = SEC_OVERSIZED;
		else kind = SEC_NOISE;

		snap = 1'($urandom_range(0, 1));
		case (kind)
			SEC_PLAIN: begin snap = 1'b0; len = $urandom_range(16, 48); end
			SEC_SNAP: begin snap = 1'b1; len = $urandom_range(24, 56); end
			SEC_BAD_SNAP: begin snap = 1'b1; len = $urandom_range(24, 40); end
			SEC_SCRAMBLED: len = $urandom_range(8, 40);
			SEC_SHORT: len = $urandom_range(1, 15);
			SEC_HDR_ON_LAST: len = snap ? 20 : 13;
			SEC_SNAP_SHORT: begin snap = 1'b1; len = $urandom_range(19, 23); end
			SEC_OVERSIZED: len = snap ? $urandom_range(89, 100) : $urandom_range(81, 92);
			default: len = $urandom_range(1, 40);
		endcase

		sec.delete();
		for (int i = 0; i < len; i++) sec.push_back(8'($urandom_range(0, 255)));
		if (kind == SEC_NOISE) return;

		// Control byte: scrambling bits, then the LLC/SNAP flag.
		ctrl = 8'($urandom_range(0, 255));
		if (kind == SEC_SCRAMBLED)
			ctrl = ctrl | (8'h04 << $urandom_range(0, 3));
		else if (snap)
			ctrl = (ctrl & ~ScrambleMask) | SnapFlag;
		else
			ctrl = ctrl & ~(ScrambleMask | SnapFlag);
		if (len > 5) sec[5] = ctrl;

		// LLC/SNAP header, or an IP version nibble that is often IPv6.
		if (snap) begin
			for (int i = 12; i < 18 && i < len; i++)
				sec[i] = (i <= 13) ? 8'haa : (i == 14) ? 8'h03 : 8'h00;
			if (kind == SEC_BAD_SNAP) begin
				pos = $urandom_range(12, 17);
				sec[pos] = sec[pos] ^ 8'($urandom_range(1, 255));
			end
		end else if (len > 12 && $urandom_range(0, 1)) begin
			sec[12][7:4] = Ipv6Version;
		end
	endfunction

	initial begin
		logic [7:0] sec[$];

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A section that ends on its very first byte.
		sec = {8'hff};
		drive_section(sec);
		// A minimal IPv4 frame with extreme MAC bytes and two payload bytes past the CRC.
		sec = {8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'h01, 8'hff, 8'h00, 8'h80, 8'h7f,
			8'hfe, 8'h01, 8'h45, 8'h00, 8'hff, 8'h55, 8'haa, 8'hff};
		drive_section(sec);
		// Scrambled and too short: the short status wins.
		sec = {8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hfc};
		drive_section(sec);
		hold_until_drained();

		// Random sections, with one stretch free of random input gaps and output stalls.
		while (sent_bytes < RandomBytes) begin
			steady <= (sent_bytes >= 100 && sent_bytes < 190);
			build_section(sec);
			drive_section(sec);
			if ($urandom_range(0, 9) == 0) hold_until_drained();
		end
		steady <= 1'b0;

		in_valid <= 1'b0;
		section_last <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/mste_pkg.sv
hw/rtl/mste_front.sv
hw/rtl/mste_queue.sv
hw/rtl/mste_back.sv
hw/rtl/mpe_section_to_ethernet.sv
hw/rtl/mste_checker.sv
tb/sv/tb_top.sv
